// ===== rtl/kbh_pkg.sv =====
package kbh_pkg;

  localparam int unsigned AccW    = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 16;
  localparam int unsigned BktW    = 17;
  localparam int unsigned IdxW    = 16;
  localparam int unsigned DivCntW = $clog2(AccW);

  localparam logic [ByteW-1:0] MaxKeyBytes  = 8'd255;
  localparam logic [BktW-1:0]  BucketsReset = 17'd1024;
  localparam logic [BktW-1:0]  BucketsMax   = 17'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_SCALE,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

endpackage

// ===== rtl/kbh_rem.sv =====
module kbh_rem (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [kbh_pkg::AccW-1:0]          dividend_i,
  input  logic [kbh_pkg::BktW-1:0]          divisor_i,
  output logic                              done_o,
  output logic [kbh_pkg::IdxW-1:0]          rem_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [kbh_pkg::DivCntW-1:0]       cnt_q, cnt_d;
  logic [kbh_pkg::AccW-1:0]          dvd_q, dvd_d;
  logic [kbh_pkg::BktW-1:0]          dvs_q, dvs_d;
  logic [kbh_pkg::IdxW-1:0]          rem_q, rem_d;
  logic [kbh_pkg::IdxW:0]            trial;
  logic [kbh_pkg::IdxW+1:0]          diff;

  assign trial = {rem_q, dvd_q[kbh_pkg::AccW-1]};
  assign diff  = {1'b0, trial} - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[kbh_pkg::AccW-2:0], 1'b0};
      if (diff[kbh_pkg::IdxW+1]) begin
        rem_d = trial[kbh_pkg::IdxW-1:0];
      end else begin
        rem_d = diff[kbh_pkg::IdxW-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == kbh_pkg::DivCntW'(kbh_pkg::AccW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  // The remainder always ends below the divisor it was taken against.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ({1'b0, rem_q} < dvs_q))
    else $error("remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider still busy when done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i) |=> (cnt_q == $past(cnt_q) + 1'b1) || done_q)
    else $error("divider step count skipped");

endmodule

// ===== rtl/key_bucket_hash.sv =====
// Key bucket hash. Key bytes arrive one per transfer on the input channel
// (key_byte_i, key_length_i, last_byte_i with in_valid_i/in_ready_o); the
// bucket index leaves on the output channel (bucket_index_o with
// out_valid_o/out_ready_i). The bucket count is written through cfg_we_i and
// cfg_wdata_i; the user must write it only while the block is idle, which
// the block itself does not enforce; 0 acts as 1, above 65536 as 65536.
// A byte that is not last is accepted, its 16-bit operand formed and
// registered, then folded in by the shared 32x16 multiplier/adder. A last
// byte is folded the same way (unless 255 bytes are already in), then takes
// a scaling pass through the same multiplier and a restoring remainder unit,
// one quotient bit a cycle. An empty key (length 0 on its first byte, marked
// last) gives bucket 0 through the emit state. The input is not ready while
// an item is in work. A finished result waits in the output register; if the
// receiver stalls, the next key's bytes are still taken until a second result
// is due. Reset clears the accumulator, the byte count and the output valid
// flag and sets the bucket count to 1024.
module key_bucket_hash (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [kbh_pkg::ByteW-1:0]       key_byte_i,
  input  logic [kbh_pkg::ByteW-1:0]       key_length_i,
  input  logic                            last_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [kbh_pkg::IdxW-1:0]        bucket_index_o,
  input  logic                            cfg_we_i,
  input  logic [kbh_pkg::BktW-1:0]        cfg_wdata_i
);

  kbh_pkg::state_e                 state_q, state_d;
  logic [kbh_pkg::AccW-1:0]        acc_q, acc_d;
  logic [kbh_pkg::ByteW-1:0]       pos_q, pos_d;
  logic [kbh_pkg::BktW-1:0]        buckets_q;
  logic [kbh_pkg::OpW-1:0]         op_q, op_d;
  logic [kbh_pkg::ByteW-1:0]       len_q, len_d;
  logic                            last_q, last_d;
  logic                            mul_mode_q, mul_mode_d;
  logic [kbh_pkg::IdxW-1:0]        result_q, result_d;
  logic                            out_valid_q, out_valid_d;
  logic [kbh_pkg::IdxW-1:0]        out_idx_q, out_idx_d;
  logic [kbh_pkg::OpW-1:0]         mul_b;
  logic [kbh_pkg::AccW-1:0]        mul_lo;
  logic [kbh_pkg::OpW-1:0]         prod_bi;
  logic [kbh_pkg::OpW-1:0]         prod_bs;
  logic [kbh_pkg::BktW-1:0]        divisor;
  logic                            div_start;
  logic                            div_done;
  logic [kbh_pkg::IdxW-1:0]        div_rem;
  logic                            in_fire;
  logic                            slot_free;

  assign in_ready_o = (state_q == kbh_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  assign prod_bi = kbh_pkg::OpW'(key_byte_i) * kbh_pkg::OpW'(pos_q);
  assign prod_bs = kbh_pkg::OpW'(key_byte_i) * kbh_pkg::OpW'(key_length_i);

  assign mul_b  = (state_q == kbh_pkg::ST_SCALE)
                  ? {{(kbh_pkg::OpW-kbh_pkg::ByteW){1'b0}}, len_q}
                  : op_q;
  assign mul_lo = acc_q * kbh_pkg::AccW'(mul_b);

  always_comb begin
    if (buckets_q == '0) begin
      divisor = kbh_pkg::BktW'(1);
    end else if (buckets_q > kbh_pkg::BucketsMax) begin
      divisor = kbh_pkg::BucketsMax;
    end else begin
      divisor = buckets_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    op_d        = op_q;
    len_d       = len_q;
    last_d      = last_q;
    mul_mode_d  = mul_mode_q;
    result_d    = result_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    div_start   = 1'b0;
    unique case (state_q)
      kbh_pkg::ST_IDLE: begin
        if (in_fire) begin
          len_d  = key_length_i;
          last_d = last_byte_i;
          if (pos_q == '0 && key_length_i == '0) begin
            if (last_byte_i) begin
              result_d = '0;
              acc_d    = '0;
              state_d  = kbh_pkg::ST_EMIT;
            end
          end else if (pos_q < kbh_pkg::MaxKeyBytes) begin
            if (pos_q == '0) begin
              op_d = {{(kbh_pkg::OpW-kbh_pkg::ByteW){1'b0}}, key_byte_i};
            end else if (pos_q == kbh_pkg::ByteW'(1)) begin
              op_d = prod_bs;
            end else begin
              op_d = prod_bi + kbh_pkg::OpW'(key_length_i) + kbh_pkg::OpW'(pos_q);
            end
            mul_mode_d = (pos_q > kbh_pkg::ByteW'(1));
            pos_d      = pos_q + 1'b1;
            state_d    = kbh_pkg::ST_FOLD;
          end else if (last_byte_i) begin
            state_d = kbh_pkg::ST_SCALE;
          end
        end
      end
      kbh_pkg::ST_FOLD: begin
        if (mul_mode_q) begin
          acc_d = mul_lo;
        end else begin
          acc_d = acc_q + kbh_pkg::AccW'(op_q);
        end
        state_d = last_q ? kbh_pkg::ST_SCALE : kbh_pkg::ST_IDLE;
      end
      kbh_pkg::ST_SCALE: begin
        div_start = 1'b1;
        acc_d     = '0;
        pos_d     = '0;
        state_d   = kbh_pkg::ST_DIVIDE;
      end
      kbh_pkg::ST_DIVIDE: begin
        if (div_done) begin
          result_d = div_rem;
          state_d  = kbh_pkg::ST_EMIT;
        end
      end
      kbh_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = result_q;
          state_d     = kbh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kbh_pkg::ST_IDLE;
      end
    endcase
  end

  kbh_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_lo),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kbh_pkg::ST_IDLE;
      acc_q       <= '0;
      pos_q       <= '0;
      buckets_q   <= kbh_pkg::BucketsReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        buckets_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    len_q      <= len_d;
    last_q     <= last_d;
    mul_mode_q <= mul_mode_d;
    result_q   <= result_d;
    out_idx_q  <= out_idx_d;
  end

  assign out_valid_o    = out_valid_q;
  assign bucket_index_o = out_idx_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == kbh_pkg::ST_DIVIDE))
    else $error("remainder finished outside the divide phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kbh_pkg::ST_SCALE) |=> (acc_q == '0 && pos_q == '0))
    else $error("key state not cleared after scaling");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kbh_pkg::ST_EMIT && slot_free) |=> out_valid_o)
    else $error("result not moved to the output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kbh_pkg::ST_FOLD) |=> (pos_q == $past(pos_q)))
    else $error("byte count moved during a fold");

endmodule

// ===== verif/key_bucket_hash_test.sv =====
class key_hash_tracker;
  logic [kbh_pkg::AccW-1:0]  accumulator;
  logic [kbh_pkg::ByteW-1:0] position;
  logic [kbh_pkg::BktW-1:0]  buckets;
  logic [kbh_pkg::IdxW-1:0]  expected_buckets[$];
  int                        errors;

  function new();
    accumulator = '0;
    position    = '0;
    buckets     = kbh_pkg::BucketsReset;
    errors      = 0;
  endfunction

  function void set_buckets(input logic [kbh_pkg::BktW-1:0] value);
    buckets = value;
  endfunction

  function int pending();
    return expected_buckets.size();
  endfunction

  function void note_byte(input logic [kbh_pkg::ByteW-1:0] key_byte,
                          input logic [kbh_pkg::ByteW-1:0] key_length,
                          input logic                      last);
    logic [kbh_pkg::AccW-1:0] byte_w;
    logic [kbh_pkg::AccW-1:0] len_w;
    logic [kbh_pkg::AccW-1:0] pos_w;
    logic [kbh_pkg::AccW-1:0] hash;
    logic [kbh_pkg::BktW-1:0] divisor;
    byte_w = {24'd0, key_byte};
    len_w  = {24'd0, key_length};
    pos_w  = {24'd0, position};
    // An empty key carries no byte; without the last mark it is dropped.
    if (position == '0 && key_length == '0) begin
      if (last) begin
        expected_buckets.push_back('0);
      end
      return;
    end
    if (position < kbh_pkg::MaxKeyBytes) begin
      if (position == 8'd0) begin
        accumulator = accumulator + byte_w;
      end else if (position == 8'd1) begin
        accumulator = accumulator + byte_w * len_w;
      end else begin
        accumulator = accumulator * (byte_w * pos_w + len_w + pos_w);
      end
      position = position + 8'd1;
    end
    if (!last) begin
      return;
    end
    divisor = buckets;
    if (divisor == '0) begin
      divisor = 17'd1;
    end else if (divisor > kbh_pkg::BucketsMax) begin
      divisor = kbh_pkg::BucketsMax;
    end
    hash = accumulator * len_w;
    hash = hash % {15'd0, divisor};
    expected_buckets.push_back(hash[kbh_pkg::IdxW-1:0]);
    accumulator = '0;
    position    = '0;
  endfunction

  function void check_bucket(input logic [kbh_pkg::IdxW-1:0] actual);
    logic [kbh_pkg::IdxW-1:0] expected;
    if (expected_buckets.size() == 0) begin
      $error("bucket_index: no result expected, actual %0d", actual);
      errors++;
      return;
    end
    expected = expected_buckets.pop_front();
    if (actual !== expected) begin
      $error("bucket_index mismatch: expected %0d, actual %0d", expected, actual);
      errors++;
    end
  endfunction
endclass

module key_bucket_hash_test;

  localparam int HoldCycles    = 300;
  localparam int SettleCycles  = 48;
  localparam int WatchdogLimit = 4000;
  localparam int PhaseItems    = 8;
  localparam int HoldKeys      = 20;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_ready_o;
  logic [kbh_pkg::ByteW-1:0] key_byte_i   = '0;
  logic [kbh_pkg::ByteW-1:0] key_length_i = '0;
  logic                      last_byte_i  = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i  = 1'b0;
  logic [kbh_pkg::IdxW-1:0]  bucket_index_o;
  logic                      cfg_we_i     = 1'b0;
  logic [kbh_pkg::BktW-1:0]  cfg_wdata_i  = '0;

  key_hash_tracker tracker = new();
  int              send_idle  = 0;
  int              recv_stall = 0;
  bit              hold_rx    = 1'b0;
  int              quiet_cycles = 0;

  key_bucket_hash uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .key_byte_i     (key_byte_i),
    .key_length_i   (key_length_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .bucket_index_o (bucket_index_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tracker.note_byte(key_byte_i, key_length_i, last_byte_i);
      end
      if (out_valid_o && out_ready_i) begin
        tracker.check_bucket(bucket_index_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // A long hold-off lets the block fill up while the sender keeps offering.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        hold_rx = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle  = 0;
        recv_stall = 0;
      end
      IDLE_SEND: begin
        send_idle  = 86;
        recv_stall = 0;
      end
      IDLE_RECV: begin
        send_idle  = 0;
        recv_stall = 86;
      end
      default: begin
        send_idle  = 14;
        recv_stall = 14;
      end
    endcase
  endtask

  task automatic send_byte(input logic [kbh_pkg::ByteW-1:0] key_byte,
                           input logic [kbh_pkg::ByteW-1:0] key_length,
                           input logic                      last);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    key_byte_i   <= key_byte;
    key_length_i <= key_length;
    last_byte_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_buckets(input logic [kbh_pkg::BktW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_buckets(value);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic send_random_key(output int sent);
    int                        kind;
    int                        count;
    logic [kbh_pkg::ByteW-1:0] length;
    kind = $urandom_range(0, 99);
    sent = 0;
    if (kind < 75) begin
      count  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      length = count[kbh_pkg::ByteW-1:0];
      for (int k = 0; k < count; k++) begin
        send_byte(kbh_pkg::ByteW'($urandom_range(0, 255)), length, k == count - 1);
      end
      sent = count;
    end else if (kind < 85) begin
      // Broken key: the length is random, may disagree with the byte count and may change.
      count  = $urandom_range(1, 12);
      length = kbh_pkg::ByteW'($urandom_range(0, 255));
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          length = kbh_pkg::ByteW'($urandom_range(0, 255));
        end
        send_byte(kbh_pkg::ByteW'($urandom_range(0, 255)), length, k == count - 1);
      end
      sent = count;
    end else if (kind < 93) begin
      send_byte(kbh_pkg::ByteW'($urandom_range(0, 255)), 8'd0, 1'b1);
      sent = 1;
    end else begin
      send_byte(kbh_pkg::ByteW'($urandom_range(0, 255)), 8'd0, 1'b0);
    end
  endtask

  initial begin
    logic [kbh_pkg::BktW-1:0] phase_buckets[8];
    idle_mode_e               phase_modes[8];
    int                       total;
    int                       sent;

    phase_buckets = '{kbh_pkg::BucketsMax, 17'd0, 17'h1FFFF, 17'd1, 17'd65535,
                      17'($urandom_range(1, 65536)), 17'd3, 17'($urandom_range(0, 131071))};
    phase_modes   = '{IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_SEND, IDLE_RECV,
                      IDLE_BOTH, IDLE_NONE};

    @(posedge rst_ni);
    @(negedge clk_i);

    set_idling(IDLE_NONE);
    send_byte(8'h00, 8'd0, 1'b1);
    send_byte(8'h5A, 8'd0, 1'b0);
    send_byte(8'hFF, 8'd1, 1'b1);
    send_byte(8'h00, 8'd1, 1'b1);
    send_byte(8'hFF, 8'd2, 1'b0);
    send_byte(8'hFF, 8'd2, 1'b1);
    send_byte(8'hFF, 8'd255, 1'b0);
    send_byte(8'hFF, 8'd255, 1'b0);
    send_byte(8'hFF, 8'd255, 1'b1);
    send_byte(8'h61, 8'd4, 1'b0);
    send_byte(8'h62, 8'd4, 1'b0);
    send_byte(8'h63, 8'd4, 1'b0);
    send_byte(8'h64, 8'd4, 1'b1);
    send_byte(8'h07, 8'd3, 1'b0);
    send_byte(8'h09, 8'd0, 1'b0);
    send_byte(8'h0B, 8'd3, 1'b1);
    send_byte(8'hAA, 8'h55, 1'b0);
    send_byte(8'h55, 8'hAA, 1'b1);
    send_byte(8'h00, 8'd3, 1'b0);
    send_byte(8'h00, 8'd3, 1'b0);
    send_byte(8'h00, 8'd3, 1'b1);
    drain_results();

    for (int p = 0; p < 8; p++) begin
      write_buckets(phase_buckets[p]);
      set_idling(phase_modes[p]);
      total = 0;
      while (total < PhaseItems) begin
        send_random_key(sent);
        total += sent;
      end
      drain_results();
    end

    write_buckets(17'd997);
    set_idling(IDLE_NONE);
    hold_rx = 1'b1;
    for (int k = 0; k < HoldKeys; k++) begin
      send_byte(kbh_pkg::ByteW'($urandom_range(0, 255)), 8'd2, 1'b0);
      send_byte(kbh_pkg::ByteW'($urandom_range(0, 255)), 8'd2, 1'b1);
    end
    drain_results();

    // A key longer than the byte counter can hold: the extra bytes are dropped.
    write_buckets(kbh_pkg::BucketsMax);
    for (int k = 0; k < 258; k++) begin
      send_byte(kbh_pkg::ByteW'($urandom_range(0, 255)), 8'd255, k == 257);
    end
    drain_results();

    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
